[sv/vgle_pkg.sv]
// ---------------------------------------------------------------------------
// vgle_pkg
// Shared constants, types and helper functions of the voting grid estimator.
// ---------------------------------------------------------------------------
package vgle_pkg;

    // sizes of the anchor chain
    localparam int NUM_CELLS  = 16;
    localparam int CELL_LAT   = 3;
    localparam int AIDX_W     = $clog2(NUM_CELLS);
    localparam int ACNT_W     = $clog2(NUM_CELLS + 1);
    localparam int SCORE_W    = $clog2(NUM_CELLS + 1);

    // coordinate widths
    localparam int COORD_W    = 24;
    localparam int SW         = 28;
    localparam int MAG_W      = 27;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int RING_W     = 2 * (COORD_W + 1);

    // grid scan
    localparam int CELLS_SIDE = 256;
    localparam int IDX_W      = $clog2(CELLS_SIDE + 1);
    localparam int DRAIN_LAST = NUM_CELLS * CELL_LAT + 1;
    localparam int DR_W       = $clog2(DRAIN_LAST + 1);

    // centroid accumulation and divider
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 17;
    localparam int DVD_W      = 48;
    localparam int DVS_W      = CNT_W + 1;
    localparam int DCNT_W     = $clog2(DVD_W);

    // register indexes
    localparam logic REG_TOL = 1'b0;
    localparam logic REG_CA  = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] r;
    } anchor_t;

    typedef struct packed {
        logic               prep;
        logic               clear;
        logic [COORD_W-1:0] tol;
        logic [SW-1:0]      side;
    } cell_ctl_t;

    typedef struct packed {
        logic               valid;
        logic [SW-1:0]      cx;
        logic [SW-1:0]      cy;
        logic [SCORE_W-1:0] score;
    } beat_t;

    // distance from a point to the nearest edge of a span, zero inside
    function automatic logic [MAG_W-1:0] gap_f(input logic signed [SW-1:0] p,
                                               input logic signed [SW-1:0] lo,
                                               input logic signed [SW-1:0] hi);
        logic signed [SW-1:0] d;
        if (p < lo)
            d = lo - p;
        else if (p > hi)
            d = p - hi;
        else
            d = '0;
        return d[MAG_W-1:0];
    endfunction

    // distance from a point to the farther edge of a span
    function automatic logic [MAG_W-1:0] far_f(input logic signed [SW-1:0] p,
                                               input logic signed [SW-1:0] lo,
                                               input logic signed [SW-1:0] hi);
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] d;
        a = p - lo;
        b = hi - p;
        d = (a > b) ? a : b;
        return d[MAG_W-1:0];
    endfunction

endpackage

[sv/voting_grid_location_estimator_core.sv]
// ---------------------------------------------------------------------------
// voting_grid_location_estimator_core
// Loads anchors, scans a grid of square cells through a chain of anchor cells and
// reports the centroid of the best voted cells.
// ---------------------------------------------------------------------------
// an anchor without last_anchor is taken while the block stays idle
// an estimate runs the cell side divide, the grid scan, the chain drain and
//   the two centroid divides, skipped without a vote
// the grid has at most 256 cells along x and y; one grid cell per cycle within a column
// with fewer than three anchors the result comes the cycle after start
// done strobes the result for one cycle, new beats are taken from then on;
// reset clears the anchor set, registers go to 100 m tolerance, 20 cells
module voting_grid_location_estimator_core import vgle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] anchor_x,
    input  logic [COORD_W-1:0] anchor_y,
    input  logic [COORD_W-1:0] anchor_range,
    input  logic               last_anchor,
    output logic               done,
    output logic [COORD_W-1:0] est_x,
    output logic [COORD_W-1:0] est_y,
    output logic               est_valid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIVS  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DIVX  = 3'd5;
    localparam logic [2:0] S_DIVY  = 3'd6;

    logic [2:0]          state_reg;
    logic [COORD_W-1:0]  tol_reg;
    logic [6:0]          ca_reg;
    logic [ACNT_W-1:0]   count_reg;
    logic [COORD_W-1:0]  minx_reg, maxx_reg, miny_reg, maxy_reg, maxr_reg;
    logic signed [SW-1:0] x0_reg, x1_reg, y0_reg, y1_reg, side_reg;
    logic signed [SW-1:0] cx_reg, cy_reg;
    logic [IDX_W-1:0]    i_reg, j_reg;
    logic [DR_W-1:0]     drain_reg;
    logic [SCORE_W-1:0]  best_reg;
    logic signed [SUM_W-1:0] sumx_reg, sumy_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [COORD_W-1:0]  qx_reg;
    logic [COORD_W-1:0]  est_x_reg, est_y_reg;
    logic                est_valid_reg, done_reg;

    logic                accept, cfg_wr, finish;
    logic [ACNT_W-1:0]   count_next;
    logic [COORD_W+1:0]  w_span, h_span, side_span;
    logic [6:0]          ca_eff;
    logic                div_start, div_done;
    logic [DVD_W-1:0]    div_dividend, div_quotient;
    logic [DVS_W-1:0]    div_divisor;
    logic [COORD_W-1:0]  q_sat;
    logic                issue;
    cell_ctl_t           ctl;
    beat_t               chain [NUM_CELLS+1];
    beat_t               end_beat;
    logic signed [SW:0]  term_x, term_y;

    assign accept     = start && (state_reg == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign count_next = (count_reg < ACNT_W'(NUM_CELLS)) ? (count_reg + 1'b1) : count_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CA) ? {25'b0, ca_reg} : {8'b0, tol_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 24'd25600;
            ca_reg  <= 7'd20;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_CA)
                ca_reg <= pwdata[6:0];
            else
                tol_reg <= pwdata[COORD_W-1:0];
        end
    end

    // cell side from the widened box
    always_comb
    begin
        w_span    = {2'b0, maxx_reg} - {2'b0, minx_reg} + {1'b0, maxr_reg, 1'b0};
        h_span    = {2'b0, maxy_reg} - {2'b0, miny_reg} + {1'b0, maxr_reg, 1'b0};
        side_span = (w_span < h_span) ? w_span : h_span;
        ca_eff    = (ca_reg == 7'd0) ? 7'd1 : ca_reg;
    end

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = {n_reg, 1'b0};
        case (state_reg)
            S_PREP:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(side_span);
                div_divisor  = DVS_W'(ca_eff);
            end
            S_DRAIN:
            begin
                div_start    = (drain_reg == DR_W'(DRAIN_LAST)) && (best_reg != '0);
                div_dividend = (sumx_reg > 0) ? (DVD_W'(sumx_reg) + DVD_W'(n_reg)) : '0;
            end
            S_DIVX:
            begin
                div_start    = div_done;
                div_dividend = (sumy_reg > 0) ? (DVD_W'(sumy_reg) + DVD_W'(n_reg)) : '0;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    vgle_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign q_sat = (|div_quotient[DVD_W-1:COORD_W]) ? '1 : div_quotient[COORD_W-1:0];

    // end of an estimate, also with a set too small
    always_comb
    begin
        finish = 1'b0;
        case (state_reg)
            S_IDLE:  finish = accept && last_anchor && (count_next < ACNT_W'(3));
            S_DRAIN: finish = (drain_reg == DR_W'(DRAIN_LAST)) && (best_reg == '0);
            S_DIVY:  finish = div_done;
            default: finish = 1'b0;
        endcase
    end

    // grid scan issue
    assign issue = (state_reg == S_SCAN) && (i_reg < IDX_W'(CELLS_SIDE)) && (cx_reg < x1_reg)
                   && (j_reg < IDX_W'(CELLS_SIDE)) && (cy_reg < y1_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            minx_reg      <= '1;
            miny_reg      <= '1;
            maxx_reg      <= '0;
            maxy_reg      <= '0;
            maxr_reg      <= '0;
            done_reg      <= 1'b0;
            est_valid_reg <= 1'b0;
            drain_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (count_reg < ACNT_W'(NUM_CELLS))
                        begin
                            count_reg <= count_next;
                            if (anchor_x < minx_reg)     minx_reg <= anchor_x;
                            if (anchor_x > maxx_reg)     maxx_reg <= anchor_x;
                            if (anchor_y < miny_reg)     miny_reg <= anchor_y;
                            if (anchor_y > maxy_reg)     maxy_reg <= anchor_y;
                            if (anchor_range > maxr_reg) maxr_reg <= anchor_range;
                        end
                        if (last_anchor && !finish)
                            state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_DIVS;
                end
                S_DIVS:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SCAN;
                        i_reg     <= '0;
                        j_reg     <= '0;
                    end
                end
                S_SCAN:
                begin
                    if ((i_reg < IDX_W'(CELLS_SIDE)) && (cx_reg < x1_reg))
                    begin
                        if (issue)
                            j_reg <= j_reg + 1'b1;
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= '0;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == DR_W'(DRAIN_LAST))
                        state_reg <= (best_reg == '0) ? S_IDLE : S_DIVX;
                end
                S_DIVX:
                begin
                    if (div_done)
                        state_reg <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (div_done)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // result beat and set clear
            if (finish)
            begin
                state_reg     <= S_IDLE;
                done_reg      <= 1'b1;
                est_valid_reg <= (state_reg == S_DIVY);
                count_reg     <= '0;
                minx_reg      <= '1;
                miny_reg      <= '1;
                maxx_reg      <= '0;
                maxy_reg      <= '0;
                maxr_reg      <= '0;
            end
        end
    end

    // box, cursors and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PREP)
        begin
            x0_reg <= $signed({{(SW-COORD_W){1'b0}}, minx_reg} - {{(SW-COORD_W){1'b0}}, maxr_reg});
            x1_reg <= $signed({{(SW-COORD_W){1'b0}}, maxx_reg} + {{(SW-COORD_W){1'b0}}, maxr_reg});
            y0_reg <= $signed({{(SW-COORD_W){1'b0}}, miny_reg} - {{(SW-COORD_W){1'b0}}, maxr_reg});
            y1_reg <= $signed({{(SW-COORD_W){1'b0}}, maxy_reg} + {{(SW-COORD_W){1'b0}}, maxr_reg});
        end
        if ((state_reg == S_DIVS) && div_done)
        begin
            side_reg <= (div_quotient == '0) ? SW'(1) : $signed(div_quotient[SW-1:0]);
            cx_reg   <= x0_reg;
            cy_reg   <= y0_reg;
        end
        if ((state_reg == S_SCAN) && (i_reg < IDX_W'(CELLS_SIDE)) && (cx_reg < x1_reg))
        begin
            if (issue)
                cy_reg <= cy_reg + side_reg;
            else
            begin
                cx_reg <= cx_reg + side_reg;
                cy_reg <= y0_reg;
            end
        end
        if ((state_reg == S_DIVX) && div_done)
            qx_reg <= q_sat;
        if (finish)
        begin
            est_x_reg <= (state_reg == S_DIVY) ? qx_reg : '0;
            est_y_reg <= (state_reg == S_DIVY) ? q_sat : '0;
        end
    end

    // chain control
    always_comb
    begin
        ctl.prep  = (state_reg == S_PREP);
        ctl.clear = finish;
        ctl.tol   = tol_reg;
        ctl.side  = side_reg;
    end

    always_comb
    begin
        chain[0].valid = issue;
        chain[0].cx    = cx_reg;
        chain[0].cy    = cy_reg;
        chain[0].score = '0;
    end

    // anchor cell chain
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        vgle_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .load     (accept && (count_reg == ACNT_W'(k))),
            .anc      ({anchor_x, anchor_y, anchor_range}),
            .beat_in  (chain[k]),
            .beat_out (chain[k+1])
        );
    end

    assign end_beat = chain[NUM_CELLS];
    assign term_x   = {end_beat.cx, 1'b0} + {side_reg[SW-1], side_reg};
    assign term_y   = {end_beat.cy, 1'b0} + {side_reg[SW-1], side_reg};

    // best score and centre sums at the end of the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
            sumx_reg <= '0;
            sumy_reg <= '0;
            n_reg    <= '0;
        end
        else if (state_reg == S_PREP)
        begin
            best_reg <= '0;
            sumx_reg <= '0;
            sumy_reg <= '0;
            n_reg    <= '0;
        end
        else if (end_beat.valid && (end_beat.score != '0))
        begin
            if (end_beat.score > best_reg)
            begin
                best_reg <= end_beat.score;
                sumx_reg <= {{(SUM_W-SW-1){term_x[SW]}}, term_x};
                sumy_reg <= {{(SUM_W-SW-1){term_y[SW]}}, term_y};
                n_reg    <= CNT_W'(1);
            end
            else if (end_beat.score == best_reg)
            begin
                sumx_reg <= sumx_reg + {{(SUM_W-SW-1){term_x[SW]}}, term_x};
                sumy_reg <= sumy_reg + {{(SUM_W-SW-1){term_y[SW]}}, term_y};
                n_reg    <= n_reg + 1'b1;
            end
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign est_x     = est_x_reg;
    assign est_y     = est_y_reg;
    assign est_valid = est_valid_reg;

endmodule

[sv/vgle_div.sv]
// ---------------------------------------------------------------------------
// vgle_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ---------------------------------------------------------------------------
module vgle_div import vgle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic              run_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_sh;
    logic              ge;
    logic [DVS_W:0]    rem_diff;

    // one trial subtraction
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_diff = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= rem_diff[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/vgle_cell.sv]
// ---------------------------------------------------------------------------
// vgle_cell
// One anchor of the chain: adds its vote to each grid cell beat passing by.
// ---------------------------------------------------------------------------
module vgle_cell import vgle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      load,
    input  anchor_t   anc,
    input  beat_t     beat_in,
    output beat_t     beat_out
);

    anchor_t           anc_reg;
    logic              act_reg;
    logic [RING_W-1:0] in2_reg;
    logic [RING_W-1:0] out2_reg;

    logic [COORD_W-1:0] inner;
    logic [COORD_W:0]   outer;

    beat_t             beat_a_reg;
    logic [MAG_W-1:0]  gx_reg, gy_reg, fx_reg, fy_reg;
    beat_t             beat_b_reg;
    logic [SQ_W-1:0]   sgx_reg, sgy_reg, sfx_reg, sfy_reg;
    beat_t             beat_c_reg;

    logic signed [SW-1:0] px, py, lox, hix, loy, hiy;
    logic [DIST_W-1:0]    dmin, dmax;
    logic                 vote;
    beat_t                beat_vote;

    // anchor storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 1'b0;
        else if (ctl.clear)
            act_reg <= 1'b0;
        else if (load)
            act_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            anc_reg <= anc;
    end

    // ring bounds squared
    always_comb
    begin
        inner = (anc_reg.r > ctl.tol) ? (anc_reg.r - ctl.tol) : '0;
        outer = {1'b0, anc_reg.r} + {1'b0, ctl.tol};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prep)
        begin
            in2_reg  <= RING_W'(inner * inner);
            out2_reg <= outer * outer;
        end
    end

    // stage a: distances to the cell edges
    always_comb
    begin
        px  = $signed({{(SW-COORD_W){1'b0}}, anc_reg.x});
        py  = $signed({{(SW-COORD_W){1'b0}}, anc_reg.y});
        lox = $signed(beat_in.cx);
        hix = $signed(beat_in.cx + ctl.side);
        loy = $signed(beat_in.cy);
        hiy = $signed(beat_in.cy + ctl.side);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_a_reg <= '0;
            beat_b_reg <= '0;
            beat_c_reg <= '0;
        end
        else
        begin
            beat_a_reg <= beat_in;
            beat_b_reg <= beat_a_reg;
            beat_c_reg <= beat_vote;
        end
    end

    always_ff @(posedge clk)
    begin
        gx_reg <= gap_f(px, lox, hix);
        gy_reg <= gap_f(py, loy, hiy);
        fx_reg <= far_f(px, lox, hix);
        fy_reg <= far_f(py, loy, hiy);
    end

    // stage b: squares
    always_ff @(posedge clk)
    begin
        sgx_reg <= gx_reg * gx_reg;
        sgy_reg <= gy_reg * gy_reg;
        sfx_reg <= fx_reg * fx_reg;
        sfy_reg <= fy_reg * fy_reg;
    end

    // stage c: ring test
    always_comb
    begin
        dmin = {1'b0, sgx_reg} + {1'b0, sgy_reg};
        dmax = {1'b0, sfx_reg} + {1'b0, sfy_reg};
        vote = act_reg && beat_b_reg.valid
               && (dmin <= {{(DIST_W-RING_W){1'b0}}, out2_reg})
               && ({{(DIST_W-RING_W){1'b0}}, in2_reg} <= dmax);
        beat_vote       = beat_b_reg;
        beat_vote.score = beat_b_reg.score + SCORE_W'(vote);
    end

    assign beat_out = beat_c_reg;

endmodule

[sv/vgle_checker.sv]
// ---------------------------------------------------------------------------
// vgle_checker
// Port level checks of the estimator, bound to the top level.
// ---------------------------------------------------------------------------
module vgle_checker import vgle_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               last_anchor,
    input logic               done,
    input logic [COORD_W-1:0] est_x,
    input logic [COORD_W-1:0] est_y,
    input logic               est_valid
);

    // an invalid result carries zero coordinates
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !est_valid) |-> (est_x == '0 && est_y == '0))
        else $error("invalid result with nonzero coordinates");

    // the result beat comes as the block goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // leaving the busy phase always delivers a result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("estimate ended without result");

    // a plain anchor beat does not start an estimate
    a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_anchor) |=> (!busy && !done))
        else $error("anchor load started work");

endmodule

bind voting_grid_location_estimator_core vgle_checker u_vgle_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_anchor (last_anchor),
    .done        (done),
    .est_x       (est_x),
    .est_y       (est_y),
    .est_valid   (est_valid)
);
